[sv/assert_macros.svh]
// Assertion macros shared by the roulette wheel selection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RWS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rws assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RWS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rws assertion failed");

`else

`define RWS_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define RWS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[sv/rws_pkg.sv]
// Shared types and constants for roulette wheel selection.
`timescale 1ns / 1ps

package rws_pkg;

    localparam int FIT_W  = 32;
    localparam int RAND_W = 32;
    localparam int SUM_W  = 40;
    localparam int THR_W  = 41;
    localparam int PROD_W = 64;
    localparam int IDX_W  = 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_load;
        logic accept_draw;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic rd;
        logic cmp;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seek_done;
        logic out_free;
    } t_status;

endpackage

[sv/rws_ctrl.sv]
// Controller state machine for roulette wheel selection.
`timescale 1ns / 1ps

module rws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_kind,
    input  rws_pkg::t_status i_status,
    output logic             o_in_stall,
    output rws_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_LO = 3'd1;
    localparam logic [2:0] S_MUL_HI = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_SEEK   = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == rws_pkg::KIND_DRAW) begin
                        o_cmd.accept_draw = 1'b1;
                        n_state           = S_MUL_LO;
                    end else begin
                        o_cmd.accept_load = 1'b1;
                    end
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SEEK;
            end
            S_SEEK: begin
                if (i_status.seek_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SEEK;
            end
            S_DONE: begin
                // hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/rws_dp.sv]
// Datapath for roulette wheel selection: prefix memory, multiplier, search, output.
`timescale 1ns / 1ps

module rws_dp #(
    parameter int MAX_POP = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rws_pkg::t_cmd                  i_cmd,
    output rws_pkg::t_status               o_status,
    input  logic                           i_restart,
    input  logic [rws_pkg::FIT_W-1:0]      i_fitness_value,
    input  logic [rws_pkg::RAND_W-1:0]     i_random_fraction,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [rws_pkg::IDX_W-1:0]      o_selected_index,
    output logic                           o_empty_error
);

    localparam int AW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
    localparam int CW = $clog2(MAX_POP + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_POP);

    logic [rws_pkg::SUM_W-1:0]  r_mem [MAX_POP];
    logic [rws_pkg::SUM_W-1:0]  r_rd;
    logic [CW-1:0]              r_count;
    logic [rws_pkg::SUM_W-1:0]  r_total;
    logic [rws_pkg::RAND_W-1:0] r_rand;
    logic                       r_err;
    logic [rws_pkg::PROD_W-1:0] r_mul;
    logic [rws_pkg::PROD_W-1:0] r_plo;
    logic [rws_pkg::THR_W-1:0]  r_thr;
    logic [CW-1:0]              r_lo;
    logic [CW-1:0]              r_hi;
    logic [CW-1:0]              r_mid;
    logic                       r_out_valid;
    logic [rws_pkg::IDX_W-1:0]  r_out_idx;
    logic                       r_out_err;

    logic [CW-1:0]              w_base_count;
    logic [rws_pkg::SUM_W-1:0]  w_base_total;
    logic [rws_pkg::SUM_W:0]    w_new_total;
    logic [rws_pkg::SUM_W-1:0]  w_sat_total;
    logic [rws_pkg::RAND_W-1:0] w_mul_b;
    logic [rws_pkg::THR_W-1:0]  w_thr;
    logic [CW:0]                w_mid_sum;
    logic [CW-1:0]              w_idx;
    logic [CW+rws_pkg::IDX_W-1:0] w_idx_ext;
    logic                       w_out_free;

    // restart empties the population before the append
    assign w_base_count = i_restart ? '0 : r_count;
    assign w_base_total = i_restart ? '0 : r_total;
    assign w_new_total  = {1'b0, w_base_total} + (rws_pkg::SUM_W + 1)'(i_fitness_value);
    assign w_sat_total  = w_new_total[rws_pkg::SUM_W] ? '1 : w_new_total[rws_pkg::SUM_W-1:0];

    // zero total: weigh every entry one, so multiply by the count instead
    always_comb begin
        if (i_cmd.mul_lo) begin
            w_mul_b = (r_total == '0) ? rws_pkg::RAND_W'(r_count) : r_total[31:0];
        end else begin
            w_mul_b = rws_pkg::RAND_W'(r_total[rws_pkg::SUM_W-1:32]);
        end
    end

    // ceil(r * total / 2^32): prefix * 2^32 < r * total iff prefix < this
    assign w_thr = rws_pkg::THR_W'(r_mul[rws_pkg::SUM_W-1:0])
                 + rws_pkg::THR_W'(r_plo[63:32])
                 + rws_pkg::THR_W'(|r_plo[31:0]);

    assign w_mid_sum = (CW + 1)'(r_lo) + (CW + 1)'(r_hi);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_status.seek_done = (r_lo == r_hi);
    assign o_status.out_free  = w_out_free;

    assign w_idx     = (r_lo == '0) ? '0 : r_lo - CW'(1);
    assign w_idx_ext = {{rws_pkg::IDX_W{1'b0}}, w_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load && (w_base_count < MAX_C)) begin
            r_mem[w_base_count[AW-1:0]] <= w_base_total;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[w_mid_sum[AW:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.accept_load) begin
            if (w_base_count < MAX_C) begin
                r_count <= w_base_count + CW'(1);
                r_total <= w_sat_total;
            end else begin
                r_count <= w_base_count;
                r_total <= w_base_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_draw) begin
            r_rand <= i_random_fraction;
            r_err  <= (r_count == '0);
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_mul <= rws_pkg::PROD_W'(r_rand) * rws_pkg::PROD_W'(w_mul_b);
        end
        if (i_cmd.mul_hi) begin
            r_plo <= r_mul;
        end
        if (i_cmd.sum) begin
            r_thr <= w_thr;
            if (r_total == '0) begin
                // uniform wheel: the hit count is the threshold itself
                r_lo <= w_thr[CW-1:0];
                r_hi <= w_thr[CW-1:0];
            end else begin
                r_lo <= '0;
                r_hi <= r_count;
            end
        end
        if (i_cmd.rd) begin
            r_mid <= w_mid_sum[CW:1];
        end
        if (i_cmd.cmp) begin
            if ({1'b0, r_rd} < r_thr) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.out_load) begin
            r_out_idx <= r_err ? '0 : w_idx_ext[rws_pkg::IDX_W-1:0];
            r_out_err <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_idx;
    assign o_empty_error    = r_out_err;

endmodule

[sv/roulette_wheel_selection_core.sv]
// Roulette wheel selection core: fitness-proportionate draw over loaded prefix sums.
//
// Input channel (i_in_valid / o_in_stall) carries one item: i_kind selects a load
// (append i_fitness_value, Q16.16; i_restart starts a new population at entry zero)
// or a draw (i_random_fraction, Q0.32). Output channel (o_out_valid / i_out_stall)
// returns one item per draw: o_selected_index and o_empty_error. Loads return nothing.
// Loads may follow back to back; a load when the population is full is dropped. A draw
// goes through the shared 32x32 multiplier twice, then one state forms the threshold,
// then a binary search of the prefix memory runs with one registered read per step
// (a read state, then a compare state) before the result goes to the output register.
// A zero total gives a uniform wheel and skips the search. The input stalls while a
// draw is in progress. The result sits in an output register, so a new item is taken
// while a result still waits; if the receiver stalls, a finished draw holds until
// the register frees. Reset clears the entry count, total and output valid; the
// prefix memory needs no clearing pass since only loaded entries are read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module roulette_wheel_selection_core #(
    parameter int MAX_POP = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic                       i_restart,
    input  logic [rws_pkg::FIT_W-1:0]  i_fitness_value,
    input  logic [rws_pkg::RAND_W-1:0] i_random_fraction,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rws_pkg::IDX_W-1:0]  o_selected_index,
    output logic                       o_empty_error
);

    rws_pkg::t_cmd    w_cmd;
    rws_pkg::t_status w_status;
    logic             w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    rws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rws_dp #(
        .MAX_POP (MAX_POP)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_restart         (i_restart),
        .i_fitness_value   (i_fitness_value),
        .i_random_fraction (i_random_fraction),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_selected_index  (o_selected_index),
        .o_empty_error     (o_empty_error)
    );

    `RWS_ASSERT_NEXT(a_draw_blocks, i_clk, i_rst_n, w_in_acc && (i_kind == rws_pkg::KIND_DRAW), o_in_stall)
    `RWS_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, w_in_acc && (i_kind == rws_pkg::KIND_LOAD), !o_in_stall)
    `RWS_ASSERT_IMPLY(a_out_from_draw, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))
    `RWS_ASSERT_IMPLY(a_empty_index, i_clk, i_rst_n, o_out_valid && o_empty_error, o_selected_index == '0)

endmodule
